[src/pdh_pkg.sv]
`default_nettype none

package pdh_pkg;

	// Datapath lane width: wide enough for the larger modulus
	localparam int unsigned LANE_W = 30;

	typedef logic [LANE_W-1:0] lane_t;

	// Moduli and hash base
	localparam logic [26:0] MOD_FIRST  = 27'd131807699;
	localparam logic [29:0] MOD_SECOND = 30'd1000000009;
	localparam logic [7:0]  HASH_BASE  = 8'd157;

	// Base left-aligned in a lane, for the serial multiplier
	localparam lane_t BASE_ALIGNED = {HASH_BASE, 22'd0};

	// Multiplier step counts: base multiply and full-width multiply
	localparam logic [4:0] BASE_STEPS = 5'd8;
	localparam logic [4:0] FULL_STEPS = 5'd30;

	// Operation codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic take;        // latch the incoming item
		logic set_trivial; // result needs no arithmetic
		logic rd_first;    // first table reads
		logic mul_start;   // load the modular multipliers
		logic commit;      // final add/subtract, table write
		logic out_load;    // move result to output register
	} pdh_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       bad_range;
		logic       full;
		logic       mul_done;
		logic       out_free;
	} pdh_stat_t;

endpackage

`default_nettype wire

[src/pdh_if.sv]
`default_nettype none

// Command channel
interface pdh_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  char_value;
	logic [11:0] range_start;
	logic [11:0] range_end;

	modport source (output valid, output operation, output char_value,
		output range_start, output range_end, input ready);
	modport sink (input valid, input operation, input char_value,
		input range_start, input range_end, output ready);
endinterface

// Response channel
interface pdh_rsp_if;
	logic        valid;
	logic        ready;
	logic [26:0] hash_first;
	logic [29:0] hash_second;
	logic [1:0]  status;
	logic [12:0] string_length;

	modport source (output valid, output hash_first, output hash_second,
		output status, output string_length, input ready);
	modport sink (input valid, input hash_first, input hash_second,
		input status, input string_length, output ready);
endinterface

`default_nettype wire

[src/prefix_double_hash_engine.sv]
// Double-modulus rolling hash engine (base 157, moduli 131807699 and 1000000009).
// Each command transfer (clear, append, query or an ignored code) gives exactly one response.
// One command is in work at a time; the response sits in an output register, so
// the next command is taken while it waits. Clear, ignored codes, a full store
// or a bad range skip the multipliers; append runs 8 steps of the bit-serial
// modular multipliers and query 30 steps. The prefix and power tables hold
// MAX_LEN+1 entries per modulus; no clearing pass is needed after reset.
`default_nettype none

module prefix_double_hash_engine import pdh_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pdh_cmd_if.sink    cmd,
	pdh_rsp_if.source  rsp
);

	pdh_ctl_t  ctl;
	pdh_stat_t stat;
	logic      cmd_ready;

	pdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	pdh_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.operation     (cmd.operation),
		.char_value    (cmd.char_value),
		.range_start   (cmd.range_start),
		.range_end     (cmd.range_end),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.hash_first    (rsp.hash_first),
		.hash_second   (rsp.hash_second),
		.status        (rsp.status),
		.string_length (rsp.string_length)
	);

	assign cmd.ready = cmd_ready;

endmodule

`default_nettype wire

[src/pdh_modmul.sv]
`default_nettype none

// Bit-serial modular multiplier: r = (2r + y_bit * x) mod m, multiplier MSB first.
// x must be below the modulus; y is left-aligned, nsteps bits are consumed.
module pdh_modmul import pdh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire lane_t      x,
	input  wire lane_t      y,
	input  wire logic [4:0] nsteps,
	input  wire lane_t      modulus,
	output lane_t           product,
	output logic            done
);

	lane_t      x_q;
	lane_t      y_q;
	lane_t      r_q;
	logic [4:0] cnt_q;
	logic       busy_q;
	logic       done_q;

	logic [LANE_W:0] m_ext;
	logic [LANE_W:0] dbl;
	logic [LANE_W:0] dbl_red;
	logic [LANE_W:0] acc;
	logic [LANE_W:0] acc_red;

	// One step: double, reduce, conditionally add x, reduce
	always_comb begin
		m_ext   = {1'b0, modulus};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
		acc     = dbl_red + (y_q[LANE_W-1] ? {1'b0, x_q} : '0);
		acc_red = (acc >= m_ext) ? acc - m_ext : acc;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= nsteps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// Operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= acc_red[LANE_W-1:0];
			y_q <= {y_q[LANE_W-2:0], 1'b0};
		end
	end

	assign product = r_q;
	assign done    = done_q;

endmodule

`default_nettype wire

[src/pdh_datapath.sv]
`default_nettype none

// Datapath: item registers, length, prefix and power tables, four multiplier
// lanes, result and output registers.
module pdh_datapath import pdh_pkg::*; #(
	parameter int unsigned MAX_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pdh_ctl_t    ctl,
	output pdh_stat_t        stat,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_value,
	input  wire logic [11:0] range_start,
	input  wire logic [11:0] range_end,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [26:0]      hash_first,
	output logic [29:0]      hash_second,
	output logic [1:0]       status,
	output logic [12:0]      string_length
);

	localparam int unsigned AW = $clog2(MAX_LEN + 1);

	// Latched item
	logic [1:0]  op_q;
	logic [7:0]  ch_q;
	logic [11:0] a_q;
	logic [11:0] b_q;

	logic [AW-1:0] length_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q <= operation;
			ch_q <= char_value;
			a_q  <= range_start;
			b_q  <= range_end;
		end
	end

	// Range checks and table addresses
	logic [12:0]   span;
	logic [12:0]   b_next;
	logic          bad_range;
	logic          full;
	logic          is_append;
	logic          is_query;
	logic          pre_re;
	logic          pw_re;
	logic [AW-1:0] pre_raddr;
	logic [AW-1:0] pw_raddr;
	logic [AW-1:0] waddr;
	logic          wr_en;

	assign is_append = (op_q == OP_APPEND);
	assign is_query  = (op_q == OP_QUERY);
	assign span      = {1'b0, b_q} - {1'b0, a_q} + 13'd1;
	assign b_next    = {1'b0, b_q} + 13'd1;
	assign bad_range = (a_q > b_q) || (32'(b_q) >= 32'(length_q));
	assign full      = (length_q == AW'(MAX_LEN));

	assign pre_re    = ctl.rd_first || (ctl.mul_start && is_query);
	assign pw_re     = ctl.rd_first;
	assign pre_raddr = ctl.mul_start ? AW'(b_next) : (is_append ? length_q : AW'(a_q));
	assign pw_raddr  = is_append ? length_q : AW'(span);
	assign waddr     = length_q + AW'(1);
	assign wr_en     = ctl.commit && is_append;

	// Tables; entry zero is never written and reads as its fixed value
	logic [26:0] pf_mem [0:MAX_LEN];
	logic [29:0] ps_mem [0:MAX_LEN];
	logic [26:0] wf_mem [0:MAX_LEN];
	logic [29:0] ws_mem [0:MAX_LEN];

	logic [26:0] pf_rd_q;
	logic [29:0] ps_rd_q;
	logic [26:0] wf_rd_q;
	logic [29:0] ws_rd_q;
	logic        pre_zero_q;
	logic        pw_zero_q;

	lane_t r_pf;
	lane_t r_ps;
	lane_t r_wf;
	lane_t r_ws;

	logic [LANE_W:0] sum_pf;
	logic [LANE_W:0] sum_ps;
	logic [LANE_W:0] res_pf;
	logic [LANE_W:0] res_ps;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pf_mem[waddr] <= res_pf[26:0];
			ps_mem[waddr] <= res_ps[29:0];
		end
		if (pre_re) begin
			pf_rd_q    <= pf_mem[pre_raddr];
			ps_rd_q    <= ps_mem[pre_raddr];
			pre_zero_q <= (pre_raddr == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wf_mem[waddr] <= r_wf[26:0];
			ws_mem[waddr] <= r_ws;
		end
		if (pw_re) begin
			wf_rd_q   <= wf_mem[pw_raddr];
			ws_rd_q   <= ws_mem[pw_raddr];
			pw_zero_q <= (pw_raddr == '0);
		end
	end

	logic [26:0] pf_val;
	logic [29:0] ps_val;
	logic [26:0] wf_val;
	logic [29:0] ws_val;

	assign pf_val = pre_zero_q ? 27'd0 : pf_rd_q;
	assign ps_val = pre_zero_q ? 30'd0 : ps_rd_q;
	assign wf_val = pw_zero_q ? 27'd1 : wf_rd_q;
	assign ws_val = pw_zero_q ? 30'd1 : ws_rd_q;

	// Multiplier lanes: prefix lanes take base or power, power lanes take base
	logic [4:0] nsteps;
	lane_t      y_pf;
	lane_t      y_ps;
	logic [3:0] lane_done;

	assign nsteps = is_append ? BASE_STEPS : FULL_STEPS;
	assign y_pf   = is_append ? BASE_ALIGNED : LANE_W'(wf_val);
	assign y_ps   = is_append ? BASE_ALIGNED : ws_val;

	pdh_modmul u_mul_pf (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.mul_start),
		.x       (LANE_W'(pf_val)),
		.y       (y_pf),
		.nsteps  (nsteps),
		.modulus (LANE_W'(MOD_FIRST)),
		.product (r_pf),
		.done    (lane_done[0])
	);

	pdh_modmul u_mul_ps (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.mul_start),
		.x       (ps_val),
		.y       (y_ps),
		.nsteps  (nsteps),
		.modulus (MOD_SECOND),
		.product (r_ps),
		.done    (lane_done[1])
	);

	pdh_modmul u_mul_wf (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.mul_start),
		.x       (LANE_W'(wf_val)),
		.y       (BASE_ALIGNED),
		.nsteps  (nsteps),
		.modulus (LANE_W'(MOD_FIRST)),
		.product (r_wf),
		.done    (lane_done[2])
	);

	pdh_modmul u_mul_ws (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.mul_start),
		.x       (ws_val),
		.y       (BASE_ALIGNED),
		.nsteps  (nsteps),
		.modulus (MOD_SECOND),
		.product (r_ws),
		.done    (lane_done[3])
	);

	// Final step: append adds the byte, query takes P[end+1] minus the product
	always_comb begin
		if (is_append) begin
			sum_pf = {1'b0, r_pf} + (LANE_W+1)'(ch_q);
			sum_ps = {1'b0, r_ps} + (LANE_W+1)'(ch_q);
		end else begin
			sum_pf = (LANE_W+1)'(pf_val) + (LANE_W+1)'(MOD_FIRST) - {1'b0, r_pf};
			sum_ps = (LANE_W+1)'(ps_val) + (LANE_W+1)'(MOD_SECOND) - {1'b0, r_ps};
		end
		res_pf = (sum_pf >= (LANE_W+1)'(MOD_FIRST)) ? sum_pf - (LANE_W+1)'(MOD_FIRST) : sum_pf;
		res_ps = (sum_ps >= (LANE_W+1)'(MOD_SECOND)) ? sum_ps - (LANE_W+1)'(MOD_SECOND) : sum_ps;
	end

	// Result registers
	logic [26:0] res_h1_q;
	logic [29:0] res_h2_q;
	logic [1:0]  res_st_q;

	always_ff @(posedge clk) begin
		if (ctl.set_trivial) begin
			res_h1_q <= '0;
			res_h2_q <= '0;
			if (is_append && full)
				res_st_q <= ST_FULL;
			else if (is_query && bad_range)
				res_st_q <= ST_BAD_RANGE;
			else
				res_st_q <= ST_OK;
		end else if (ctl.commit) begin
			res_h1_q <= res_pf[26:0];
			res_h2_q <= res_ps[29:0];
			res_st_q <= ST_OK;
		end
	end

	// String length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (ctl.set_trivial && (op_q == OP_CLEAR)) begin
			length_q <= '0;
		end else if (wr_en) begin
			length_q <= length_q + AW'(1);
		end
	end

	// Output register
	logic        out_valid_q;
	logic [26:0] out_h1_q;
	logic [29:0] out_h2_q;
	logic [1:0]  out_st_q;
	logic [12:0] out_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_h1_q  <= res_h1_q;
			out_h2_q  <= res_h2_q;
			out_st_q  <= res_st_q;
			out_len_q <= 13'(length_q);
		end
	end

	assign rsp_valid     = out_valid_q;
	assign hash_first    = out_h1_q;
	assign hash_second   = out_h2_q;
	assign status        = out_st_q;
	assign string_length = out_len_q;

	// Status to controller
	assign stat.op        = op_q;
	assign stat.bad_range = bad_range;
	assign stat.full      = full;
	assign stat.mul_done  = &lane_done;
	assign stat.out_free  = !out_valid_q || rsp_ready;

endmodule

`default_nettype wire

[src/pdh_ctrl.sv]
`default_nettype none

// Controller: sequences one item through decode, then table read and multiply or not, then finish.
module pdh_ctrl import pdh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire pdh_stat_t stat,
	output pdh_ctl_t       ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_LOAD   = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       needs_math;

	// Append with room, or query with a good range, goes through the multipliers
	assign needs_math = ((stat.op == OP_APPEND) && !stat.full) ||
		((stat.op == OP_QUERY) && !stat.bad_range);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.take  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (needs_math) begin
					ctl.rd_first = 1'b1;
					state_nxt    = S_LOAD;
				end else begin
					ctl.set_trivial = 1'b1;
					state_nxt       = S_FINISH;
				end
			end
			S_LOAD: begin
				ctl.mul_start = 1'b1;
				state_nxt     = S_MUL;
			end
			S_MUL: begin
				if (stat.mul_done) begin
					ctl.commit = 1'b1;
					state_nxt  = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	assign cmd_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

[src/pdh_checker.sv]
`default_nettype none

// Port-level checks for the hash engine
module pdh_checker import pdh_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [26:0] hash_first,
	input wire logic [29:0] hash_second,
	input wire logic [1:0]  status,
	input wire logic [12:0] string_length
);

	logic       cmd_xfer;
	logic       rsp_xfer;
	logic [1:0] pend_q;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// Commands taken minus responses delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (cmd_xfer && !rsp_xfer)
			pend_q <= pend_q + 2'd1;
		else if (rsp_xfer && !cmd_xfer)
			pend_q <= pend_q - 2'd1;
	end

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hash_first) &&
		$stable(hash_second) && $stable(status) && $stable(string_length))
		else $error("response changed while stalled");

	// One command in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> !cmd_ready)
		else $error("command taken while another is in work");

	// Every response transfer belongs to a command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer |-> pend_q != 2'd0)
		else $error("response without command");

	// Error responses carry zero hashes
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> (hash_first == '0) && (hash_second == '0))
		else $error("nonzero hash on error status");

endmodule

bind prefix_double_hash_engine pdh_checker u_pdh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.hash_first    (rsp.hash_first),
	.hash_second   (rsp.hash_second),
	.status        (rsp.status),
	.string_length (rsp.string_length)
);

`default_nettype wire
